>>> design/scs_pkg.sv
// Shared types, constants and the per-cell schedule for the SipHash cookie pipeline.
`timescale 1ns / 1ps

package scs_pkg;

    localparam int unsigned SP_CELLS  = 32;  // half-round cells, 16 rounds
    localparam int unsigned IDX_W     = 5;   // bits to number a cell
    localparam int unsigned MSG_WORDS = 6;   // largest word list incl. length word
    localparam int unsigned OCC_W     = 6;   // holds SP_CELLS + 1

    localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_C3 = 64'h7465646279746573;

    // final word: byte length in the top byte
    localparam logic [63:0] LEN_V4 = 64'h1000000000000000;  // 16 bytes
    localparam logic [63:0] LEN_V6 = 64'h2800000000000000;  // 40 bytes

    localparam logic [63:0] FIN_FF = 64'h00000000000000ff;

    localparam logic KIND_V4 = 1'b0;
    localparam logic KIND_V6 = 1'b1;

    // rounds spent absorbing the words, length word included
    localparam logic [3:0] ABS_ROUNDS_V4 = 4'd6;
    localparam logic [3:0] ABS_ROUNDS_V6 = 4'd12;
    localparam logic [3:0] FIN_ROUNDS    = 4'd4;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } lanes_t;

    typedef struct packed {
        logic                       kind;
        lanes_t                     v;
        logic [MSG_WORDS-1:0][63:0] msg;  // msg[0] is the word being absorbed
    } stage_t;

    typedef struct packed {
        logic active;   // otherwise the cell passes its item on untouched
        logic half;     // 0: first half of a SipRound, 1: second half
        logic pre_m;    // d ^= m on entry
        logic post_m;   // a ^= m on exit, then drop the word
        logic pre_ff;   // c ^= 0xff on entry (start of finalisation)
    } op_t;

    function automatic op_t cell_op(input logic kind, input logic [IDX_W-1:0] idx);
        op_t        op;
        logic [3:0] rnd;
        logic [3:0] nabs;
        logic [4:0] nall;
        rnd    = idx[IDX_W-1:1];
        nabs   = (kind == KIND_V6) ? ABS_ROUNDS_V6 : ABS_ROUNDS_V4;
        nall   = {1'b0, nabs} + {1'b0, FIN_ROUNDS};
        op.active = ({1'b0, rnd} < nall);
        op.half   = idx[0];
        op.pre_m  = (rnd < nabs) && !rnd[0] && !idx[0];
        op.post_m = (rnd < nabs) && rnd[0] && idx[0];
        op.pre_ff = (rnd == nabs) && !idx[0];
        return op;
    endfunction

endpackage

>>> design/scs_cell.sv
// One SipHash half-round cell: a stage register with its own load enable.
`timescale 1ns / 1ps

module scs_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            up_valid,
    input  scs_pkg::stage_t up_data,
    input  scs_pkg::op_t    op,
    output logic            valid,
    output scs_pkg::stage_t data
);

    logic            valid_reg;
    logic            valid_next;
    scs_pkg::stage_t data_reg;
    scs_pkg::stage_t data_next;

    logic [63:0] m;
    logic [63:0] a0;
    logic [63:0] b0;
    logic [63:0] c0;
    logic [63:0] d0;
    logic [63:0] sa;
    logic [63:0] sc;
    logic [63:0] a1;
    logic [63:0] b1;
    logic [63:0] c1;
    logic [63:0] d1;

    always_comb
    begin
        m  = up_data.msg[0];
        a0 = up_data.v.a;
        b0 = up_data.v.b;
        c0 = up_data.v.c ^ (op.pre_ff ? scs_pkg::FIN_FF : 64'd0);
        d0 = up_data.v.d ^ (op.pre_m ? m : 64'd0);

        if (!op.half)
        begin
            sa = a0 + b0;
            sc = c0 + d0;
            b1 = {b0[50:0], b0[63:51]} ^ sa;   // rotl 13
            a1 = {sa[31:0], sa[63:32]};        // rotl 32
            d1 = {d0[47:0], d0[63:48]} ^ sc;   // rotl 16
            c1 = sc;
        end
        else
        begin
            sa = a0 + d0;
            sc = c0 + b0;
            d1 = {d0[42:0], d0[63:43]} ^ sa;   // rotl 21
            a1 = sa;
            b1 = {b0[46:0], b0[63:47]} ^ sc;   // rotl 17
            c1 = {sc[31:0], sc[63:32]};        // rotl 32
        end

        data_next = up_data;
        if (op.active)
        begin
            data_next.v.a = op.post_m ? (a1 ^ m) : a1;
            data_next.v.b = b1;
            data_next.v.c = c1;
            data_next.v.d = d1;
            if (op.post_m)
            begin
                for (int j = 0; j < scs_pkg::MSG_WORDS - 1; j++)
                begin
                    data_next.msg[j] = up_data.msg[j + 1];
                end
                data_next.msg[scs_pkg::MSG_WORDS - 1] = 64'd0;
            end
        end

        valid_next = en ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

>>> design/syn_cookie_siphash_core.sv
// Top level: SipHash-2-4 SYN-cookie generator built as a row of half-round cells.
`timescale 1ns / 1ps

//  channel | signals                          | direction | transfer when
//  --------+----------------------------------+-----------+-----------------------
//  in      | in_valid/in_ready, tuple fields   | sink      | in_valid & in_ready
//  out     | out_valid/out_ready, cookie       | source    | out_valid & out_ready
//  cfg     | cfg_valid/cfg_ready, cfg_data     | sink      | cfg_valid & cfg_ready
//
//  One tuple per cycle unless the row is full and the output is stalled; every tuple
//  passes through 32 half-round cells and then the output register before it leaves.
//  IPv4 tuples use the first 20 cells, the rest carry them through unchanged.
//  Each cell loads when it is empty or its neighbour moves, so bubbles close up
//  and input keeps flowing while the output is stalled, until the row is full.
//  Reset clears all valid bits and the secret (to zero); cfg is always ready.

module syn_cookie_siphash_core (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [63:0] them_addr_hi,
    input  logic [63:0] them_addr_lo,
    input  logic [63:0] mine_addr_hi,
    input  logic [63:0] mine_addr_lo,
    input  logic [15:0] them_port,
    input  logic [15:0] mine_port,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] cookie,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data
);

    localparam int unsigned N = scs_pkg::SP_CELLS;

    logic [63:0] key_reg;
    logic [63:0] key_next;

    logic            out_valid_reg;
    logic            out_valid_next;
    logic [63:0]     cookie_reg;
    logic [63:0]     cookie_next;

    logic [N:0]      en;          // en[N] belongs to the output register
    logic [N-1:0]    cell_valid;
    logic [N-1:0]    up_valid;
    scs_pkg::stage_t cell_data [N];
    scs_pkg::stage_t up_data   [N];
    scs_pkg::op_t    cell_ops  [N];
    scs_pkg::stage_t head;

    logic [scs_pkg::OCC_W-1:0] occ_reg;
    logic [scs_pkg::OCC_W-1:0] occ_next;

    // secret register: both key halves are the same word
    assign cfg_ready = 1'b1;

    always_comb
    begin
        key_next = (cfg_valid && cfg_ready) ? cfg_data : key_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= 64'd0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    // initial lanes and the word list, length word last
    always_comb
    begin
        head.kind = kind;
        head.v.a  = key_reg ^ scs_pkg::SIP_C0;
        head.v.b  = key_reg ^ scs_pkg::SIP_C1;
        head.v.c  = key_reg ^ scs_pkg::SIP_C2;
        head.v.d  = key_reg ^ scs_pkg::SIP_C3;
        head.msg  = '0;
        if (kind == scs_pkg::KIND_V6)
        begin
            head.msg[0] = them_addr_hi;
            head.msg[1] = them_addr_lo;
            head.msg[2] = mine_addr_hi;
            head.msg[3] = mine_addr_lo;
            head.msg[4] = {32'd0, them_port, mine_port};
            head.msg[5] = scs_pkg::LEN_V6;
        end
        else
        begin
            head.msg[0] = {16'd0, them_port, them_addr_lo[31:0]};
            head.msg[1] = {16'd0, mine_port, mine_addr_lo[31:0]};
            head.msg[2] = scs_pkg::LEN_V4;
        end
    end

    // load enables ripple back from the output register
    always_comb
    begin
        en[N] = !out_valid_reg || out_ready;
        for (int i = N - 1; i >= 0; i--)
        begin
            en[i] = !cell_valid[i] || en[i + 1];
        end
    end

    assign in_ready = en[0];

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                assign up_valid[g] = in_valid;
                assign up_data[g]  = head;
            end
            else
            begin : g_link
                assign up_valid[g] = cell_valid[g - 1];
                assign up_data[g]  = cell_data[g - 1];
            end

            assign cell_ops[g] = scs_pkg::cell_op(up_data[g].kind,
                                                  scs_pkg::IDX_W'(g));

            scs_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en[g]),
                .up_valid (up_valid[g]),
                .up_data  (up_data[g]),
                .op       (cell_ops[g]),
                .valid    (cell_valid[g]),
                .data     (cell_data[g])
            );
        end
    endgenerate

    // output register: fold the four lanes
    always_comb
    begin
        out_valid_next = en[N] ? cell_valid[N - 1] : out_valid_reg;
        cookie_next    = cell_data[N - 1].v.a ^ cell_data[N - 1].v.b
                       ^ cell_data[N - 1].v.c ^ cell_data[N - 1].v.d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[N])
        begin
            cookie_reg <= cookie_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign cookie    = cookie_reg;

    // items in flight, tracked from the port transfers
    always_comb
    begin
        occ_next = occ_reg
                 + scs_pkg::OCC_W'(in_valid && in_ready)
                 - scs_pkg::OCC_W'(out_valid && out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // a ready sink downstream means every cell can move
    a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("in_ready low while out_ready high");

    // no item appears in the first cell without an input transfer
    a_head_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cell_valid[0]) |-> $past(in_valid && in_ready))
        else $error("first cell filled without a transfer");

    // nothing lost or invented along the row
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == scs_pkg::OCC_W'($countones({cell_valid, out_valid_reg})))
        else $error("valid bits disagree with transfer count");

endmodule

>>> tb/tb_syn_cookie_siphash_core.sv
// Self-checking testbench for the SipHash-2-4 SYN-cookie core.
`timescale 1ns / 1ps

module tb_syn_cookie_siphash_core;

    localparam int DIR_N     = 18;   // rows in the directed table
    localparam int PHASE_N   = 4;    // pacing modes for the random part
    localparam int PER_PHASE = 275;  // random tuples per pacing mode
    localparam int TAIL_CYC  = 40;   // pipeline depth is 33, allow margin

    // One connection tuple, as driven on the input channel
    typedef struct packed {
        logic        kind;
        logic [63:0] them_addr_hi;
        logic [63:0] them_addr_lo;
        logic [63:0] mine_addr_hi;
        logic [63:0] mine_addr_lo;
        logic [15:0] them_port;
        logic [15:0] mine_port;
    } tuple_t;

    // The four SipHash lanes
    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } sip_state_t;

    logic        clk = 1'b0;
    logic        rst_n;

    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [63:0] them_addr_hi;
    logic [63:0] them_addr_lo;
    logic [63:0] mine_addr_hi;
    logic [63:0] mine_addr_lo;
    logic [15:0] them_port;
    logic [15:0] mine_port;

    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] cookie;

    logic        cfg_valid;
    logic        cfg_ready;
    logic [63:0] cfg_data;

    // Secret as the core should hold it, updated on each cfg transfer
    logic [63:0] secret = '0;

    // Cookies still owed by the core, oldest first
    logic [63:0] pending_cookies [$];

    // First results, kept so ignored-bit rows can be compared with each other
    logic [63:0] dir_cookies [DIR_N];
    tuple_t      dir_rows    [DIR_N];
    int          same_as     [DIR_N];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int errors       = 0;
    int n_results    = 0;
    int n_v4         = 0;
    int n_v6         = 0;
    int n_keys       = 0;
    int n_pauses     = 0;

    syn_cookie_siphash_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .them_addr_hi (them_addr_hi),
        .them_addr_lo (them_addr_lo),
        .mine_addr_hi (mine_addr_hi),
        .mine_addr_lo (mine_addr_lo),
        .them_port    (them_port),
        .mine_port    (mine_port),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cookie       (cookie),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Cookie predictor: plain SipHash-2-4 with k0 = k1 = secret
    // ------------------------------------------------------------------
    function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic sip_state_t sip_round(input sip_state_t s_in);
        sip_state_t s;
        s   = s_in;
        s.a = s.a + s.b;  s.b = rotl(s.b, 13);  s.b = s.b ^ s.a;  s.a = rotl(s.a, 32);
        s.c = s.c + s.d;  s.d = rotl(s.d, 16);  s.d = s.d ^ s.c;
        s.a = s.a + s.d;  s.d = rotl(s.d, 21);  s.d = s.d ^ s.a;
        s.c = s.c + s.b;  s.b = rotl(s.b, 17);  s.b = s.b ^ s.c;  s.c = rotl(s.c, 32);
        return s;
    endfunction

    function automatic logic [63:0] predict_cookie(input tuple_t t, input logic [63:0] k);
        logic [63:0] words [6];
        logic [7:0]  nbytes;
        sip_state_t  s;
        int          nw;
        if (t.kind == scs_pkg::KIND_V4)
        begin
            // 32-bit fields little-endian: address then port, per side
            words[0] = {16'h0, t.them_port, t.them_addr_lo[31:0]};
            words[1] = {16'h0, t.mine_port, t.mine_addr_lo[31:0]};
            nw = 2;
        end
        else
        begin
            words[0] = t.them_addr_hi;
            words[1] = t.them_addr_lo;
            words[2] = t.mine_addr_hi;
            words[3] = t.mine_addr_lo;
            words[4] = {32'h0, t.them_port, t.mine_port};
            nw = 5;
        end
        // length word: byte count in the top byte
        nbytes    = 8'(nw * 8);
        words[nw] = {nbytes, 56'h0};
        s.a = k ^ scs_pkg::SIP_C0;
        s.b = k ^ scs_pkg::SIP_C1;
        s.c = k ^ scs_pkg::SIP_C2;
        s.d = k ^ scs_pkg::SIP_C3;
        for (int i = 0; i <= nw; i++)
        begin
            s.d = s.d ^ words[i];
            s   = sip_round(s);
            s   = sip_round(s);
            s.a = s.a ^ words[i];
        end
        s.c = s.c ^ 64'hff;
        for (int i = 0; i < 4; i++)
            s = sip_round(s);
        return s.a ^ s.b ^ s.c ^ s.d;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic tuple_t mk_tuple(input logic k, input logic [63:0] th, tl, mh, ml,
                                        input logic [15:0] tp, mp);
        tuple_t t;
        t.kind         = k;
        t.them_addr_hi = th;
        t.them_addr_lo = tl;
        t.mine_addr_hi = mh;
        t.mine_addr_lo = ml;
        t.them_port    = tp;
        t.mine_port    = mp;
        return t;
    endfunction

    // Mostly random, with the all-zero and all-one extremes mixed in
    function automatic logic [63:0] rand_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [15:0] rand_port();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return 16'($urandom_range(16'hffff));
        endcase
    endfunction

    function automatic tuple_t rand_tuple();
        logic k;
        k = $urandom_range(1) ? scs_pkg::KIND_V6 : scs_pkg::KIND_V4;
        return mk_tuple(k, rand_word(), rand_word(), rand_word(), rand_word(),
                        rand_port(), rand_port());
    endfunction

    // Present one tuple at a falling edge, hold it until the transfer,
    // and return at the next falling edge with valid still high.
    task automatic send_tuple(input tuple_t t);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        kind         = t.kind;
        them_addr_hi = t.them_addr_hi;
        them_addr_lo = t.them_addr_lo;
        mine_addr_hi = t.mine_addr_hi;
        mine_addr_lo = t.mine_addr_lo;
        them_port    = t.them_port;
        mine_port    = t.mine_port;
        in_valid     = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_cookies.push_back(predict_cookie(t, secret));
        if (t.kind == scs_pkg::KIND_V6)
            n_v6++;
        else
            n_v4++;
        @(negedge clk);
    endtask

    // Stop sending and let every owed cookie come out
    task automatic drain();
        in_valid = 1'b0;
        while (pending_cookies.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Only ever called with the core idle
    task automatic write_secret(input logic [63:0] v);
        cfg_data  = v;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        secret = v;
        n_keys++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output side: random back-pressure, and the checker
    // ------------------------------------------------------------------
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= rx_stall_pct);

    always @(posedge clk)
    begin
        logic [63:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (n_results < DIR_N)
                dir_cookies[n_results] = cookie;
            n_results++;
            if (pending_cookies.size() == 0)
            begin
                $display("%0t: cookie %h with no tuple outstanding", $time, cookie);
                errors++;
            end
            else
            begin
                want = pending_cookies.pop_front();
                if (cookie !== want)
                begin
                    $display("%0t: cookie mismatch, expected %h, actual %h",
                             $time, want, cookie);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [63:0] phase_key [PHASE_N];
        int          phase_tx  [PHASE_N];
        int          phase_rx  [PHASE_N];

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        kind         = scs_pkg::KIND_V4;
        them_addr_hi = '0;
        them_addr_lo = '0;
        mine_addr_hi = '0;
        mine_addr_lo = '0;
        them_port    = '0;
        mine_port    = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;

        // Directed table. No cookie here is obvious by inspection, so every
        // row goes through the predictor; rows that differ from an earlier
        // one only in ignored bits must also give the very same cookie.
        for (int r = 0; r < DIR_N; r++)
            same_as[r] = -1;
        dir_rows[0]  = mk_tuple(scs_pkg::KIND_V4, '0, '0, '0, '0, '0, '0);
        dir_rows[1]  = mk_tuple(scs_pkg::KIND_V4, '1, '1, '1, '1, '1, '1);
        // IPv4: upper address halves and the high words are don't-care
        dir_rows[2]  = mk_tuple(scs_pkg::KIND_V4, '1, 64'hffffffff_00000000, '1,
                                64'hffffffff_00000000, '0, '0);
        same_as[2]   = 0;
        dir_rows[3]  = mk_tuple(scs_pkg::KIND_V4, '0, 64'h00000000_ffffffff, '0,
                                64'h00000000_ffffffff, '1, '1);
        same_as[3]   = 1;
        dir_rows[4]  = mk_tuple(scs_pkg::KIND_V6, '0, '0, '0, '0, '0, '0);
        dir_rows[5]  = mk_tuple(scs_pkg::KIND_V6, '1, '1, '1, '1, '1, '1);
        dir_rows[6]  = mk_tuple(scs_pkg::KIND_V6, {4{16'haaaa}}, {4{16'h5555}},
                                {4{16'haaaa}}, {4{16'h5555}}, 16'haaaa, 16'h5555);
        dir_rows[7]  = mk_tuple(scs_pkg::KIND_V6, {4{16'h5555}}, {4{16'haaaa}},
                                {4{16'h5555}}, {4{16'haaaa}}, 16'h5555, 16'haaaa);
        dir_rows[8]  = mk_tuple(scs_pkg::KIND_V4, {4{16'haaaa}}, {4{16'h5555}},
                                {4{16'haaaa}}, {4{16'h5555}}, 16'haaaa, 16'h5555);
        dir_rows[9]  = mk_tuple(scs_pkg::KIND_V4, {4{16'h5555}}, {4{16'haaaa}},
                                {4{16'h5555}}, {4{16'haaaa}}, 16'h5555, 16'haaaa);
        dir_rows[10] = mk_tuple(scs_pkg::KIND_V6, '0, '0, '0, '0, '1, '0);
        dir_rows[11] = mk_tuple(scs_pkg::KIND_V6, '0, '0, '0, '0, '0, '1);
        dir_rows[12] = mk_tuple(scs_pkg::KIND_V4, '0, '0, '0, '0, '1, '0);
        dir_rows[13] = mk_tuple(scs_pkg::KIND_V4, '0, '0, '0, '0, '0, '1);
        dir_rows[14] = mk_tuple(scs_pkg::KIND_V6, '1, '0, '0, '0, '0, '0);
        dir_rows[15] = mk_tuple(scs_pkg::KIND_V6, '0, '0, '0, '1, '0, '0);
        dir_rows[16] = mk_tuple(scs_pkg::KIND_V4, '0, 64'h1, '0, 64'h80000000,
                                16'h1, 16'h8000);
        dir_rows[17] = mk_tuple(scs_pkg::KIND_V6, 64'h20010db8_00000000,
                                64'h00000000_00000001, 64'hfe800000_00000000,
                                64'h0211_22ff_fe33_4455, 16'd443, 16'd61000);

        // Pacing modes: free running, slow sender, slow receiver, both jittery
        phase_tx[0] = 0;   phase_rx[0] = 0;   phase_key[0] = '1;
        phase_tx[1] = 60;  phase_rx[1] = 0;   phase_key[1] = {$urandom, $urandom};
        phase_tx[2] = 0;   phase_rx[2] = 60;  phase_key[2] = {$urandom, $urandom};
        phase_tx[3] = 16;  phase_rx[3] = 16;  phase_key[3] = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part runs on the reset secret, no idling
        for (int r = 0; r < DIR_N; r++)
            send_tuple(dir_rows[r]);
        drain();
        for (int r = 0; r < DIR_N; r++)
        begin
            if (same_as[r] >= 0 && dir_cookies[r] !== dir_cookies[same_as[r]])
            begin
                $display("%0t: ignored IPv4 bits changed the cookie, expected %h, actual %h",
                         $time, dir_cookies[same_as[r]], dir_cookies[r]);
                errors++;
            end
        end

        // Random part, one secret per pacing mode
        for (int p = 0; p < PHASE_N; p++)
        begin
            tx_idle_pct  = phase_tx[p];
            rx_stall_pct = phase_rx[p];
            write_secret(phase_key[p]);
            for (int i = 0; i < PER_PHASE; i++)
            begin
                // once per run, let the pipe empty completely mid-stream
                if (p == 1 && i == PER_PHASE / 2)
                begin
                    drain();
                    n_pauses++;
                end
                send_tuple(rand_tuple());
            end
            drain();
        end

        // Anything further out of the core now is a spurious cookie
        rx_stall_pct = 0;
        repeat (TAIL_CYC) @(posedge clk);

        $display("Ran %0d IPv4 and %0d IPv6 tuples under %0d secrets, %0d cookies checked,",
                 n_v4, n_v6, n_keys + 1, n_results);
        $display("across free-running, throttled and stalled pacing with %0d full drains.",
                 n_pauses);
        if (errors == 0)
            $display("syn_cookie_siphash_core test passed");
        else
            $display("syn_cookie_siphash_core test failed");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("Timed out with %0d cookies outstanding", pending_cookies.size());
        $display("syn_cookie_siphash_core test failed");
        $finish;
    end

endmodule
